// ===== design/dtm_pkg.sv =====
// ============================================================================
// dtm_pkg
// Types, constants and helper functions for the differential thrust mixer.
// ============================================================================
`default_nettype none

package dtm_pkg;

    localparam int ONE_Q14    = 16384;
    localparam int AMP_LIMIT  = 20;
    localparam int CUR_MAX    = AMP_LIMIT * ONE_Q14;

    // thrust curve coefficients, Q0.16
    localparam logic [12:0] FWD_C2 = 13'd5767;
    localparam logic [14:0] FWD_C1 = 15'd29491;
    localparam logic [12:0] REV_C2 = 13'd3932;
    localparam logic [14:0] REV_C1 = 15'd26214;

    localparam int CURVE_SH   = 36;
    localparam int TORQUE_SH  = 13;
    localparam int DRAG_SH    = 8;

    // normalisation divider: quotient bits, bits per stage, stage count
    localparam int DIV_BITS   = 15;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    localparam int CFG_IDX_W  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURGE_DAMP = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAY_DAMP  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_DAMP   = 8'd3;
    localparam logic [15:0] SPACING_RST = 16'd4096;

    localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
    localparam logic signed [23:0] MIN24 = 24'sh800000;
    localparam logic signed [15:0] MAX16 = 16'sh7FFF;
    localparam logic signed [15:0] MIN16 = 16'sh8000;

    typedef struct packed {
        logic signed [23:0] surge;
        logic signed [23:0] sway;
        logic signed [23:0] yaw;
    } t_drag;

    typedef struct packed {
        logic [18:0] a;
        logic        neg;
    } t_side;

    typedef struct packed {
        logic signed [16:0] l;
        logic signed [16:0] r;
        logic signed [32:0] p_surge;
        logic signed [32:0] p_sway;
        logic signed [32:0] p_yaw;
    } t_stg_a;

    typedef struct packed {
        logic signed [16:0] l;
        logic signed [16:0] r;
        logic               norm;
        logic               big_l;
        logic [16:0]        mx;
        logic [16:0]        rem;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] q;
        t_drag              drag;
    } t_div;

    typedef struct packed {
        t_side ls;
        t_side rs;
        t_drag drag;
    } t_cur;

    typedef struct packed {
        logic [36:0] lsq;
        logic [36:0] rsq;
        logic [33:0] llin;
        logic [33:0] rlin;
        logic        lneg;
        logic        rneg;
        t_drag       drag;
    } t_sq;

    typedef struct packed {
        logic [49:0] lquad;
        logic [49:0] rquad;
        logic [33:0] llin;
        logic [33:0] rlin;
        logic        lneg;
        logic        rneg;
        t_drag       drag;
    } t_prod;

    typedef struct packed {
        logic signed [15:0] lt;
        logic signed [15:0] rt;
        t_drag              drag;
    } t_thr;

    typedef struct packed {
        logic signed [15:0] surge;
        logic signed [33:0] tp;
        t_drag              drag;
    } t_trq;

    typedef struct packed {
        logic signed [15:0] surge;
        logic signed [23:0] torque;
        t_drag              drag;
    } t_res;

    // mix value -> motor current magnitude and sign, clamped to +-20 A
    function automatic t_side cur_of(input logic signed [16:0] v);
        logic signed [21:0] c;
        t_side s;
        c = (22'(v) <<< 4) + (22'(v) <<< 2);
        if (c > 22'(CUR_MAX)) begin
            c = 22'(CUR_MAX);
        end else if (c < -22'(CUR_MAX)) begin
            c = -22'(CUR_MAX);
        end
        s.neg = c[21];
        s.a   = c[21] ? 19'(-c) : 19'(c);
        return s;
    endfunction

    // shift right rounding half away from zero, optional negate, saturate to 24 bits
    function automatic logic signed [23:0] rnd_sat(input logic signed [33:0] v,
                                                   input int unsigned sh,
                                                   input logic negate);
        logic [33:0] mag;
        logic [33:0] m;
        logic        neg;
        mag = v[33] ? 34'(-v) : 34'(v);
        m   = (mag + (34'd1 << (sh - 1))) >> sh;
        neg = v[33] ^ negate;
        if (neg) begin
            if (m > 34'd8388608) begin
                return MIN24;
            end
            return 24'(34'd0 - m);
        end
        if (m > 34'd8388607) begin
            return MAX24;
        end
        return 24'(m);
    endfunction

endpackage

`default_nettype wire

// ===== design/differential_thrust_mixer.sv =====
// ============================================================================
// differential_thrust_mixer
// Mixes throttle and steering into two thruster currents, applies the thrust
// curves and gives surge force, yaw torque and the linear damping drags.
// ============================================================================
// Input channel: i_in_valid / o_in_ready carry one command beat (throttle,
// steering, surge, sway and yaw speed). Output channel: o_out_valid /
// i_out_ready carry one result beat per input beat, in order.
// Config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index
// selects spacing (0), surge, sway or yaw damping (1..3); other indices are
// ignored. Write only while the pipeline is empty.
// Throughput: one beat per cycle unless i_out_ready stalls the output.
// Depth: 13 register stages, set by the normalisation divider (five
// stages of three quotient bits) and the two chained multiplies of the
// thrust curve.
// Each stage holds while the one after it is full and stalled, so a stalled
// receiver fills bubbles first and back-pressure reaches o_in_ready only
// once every stage is occupied.
// Reset empties the pipeline and restores spacing to 1.0 m, damping to 0.
// ============================================================================
`default_nettype none

module differential_thrust_mixer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dtm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data,

    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [15:0]             i_throttle,
    input  wire logic signed [15:0]             i_steering,
    input  wire logic signed [15:0]             i_surge_speed,
    input  wire logic signed [15:0]             i_sway_speed,
    input  wire logic signed [15:0]             i_yaw_speed,

    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [15:0]                  o_surge_force,
    output logic signed [23:0]                  o_yaw_torque,
    output logic signed [23:0]                  o_surge_drag,
    output logic signed [23:0]                  o_sway_drag,
    output logic signed [23:0]                  o_yaw_drag
);

    localparam int STG_A = 0;
    localparam int STG_B = 1;
    localparam int STG_C = STG_B + dtm_pkg::DIV_STAGES + 1;
    localparam int STG_E = STG_C + 1;
    localparam int STG_F = STG_E + 1;
    localparam int STG_G = STG_F + 1;
    localparam int STG_H = STG_G + 1;
    localparam int STG_I = STG_H + 1;
    localparam int NSTG  = STG_I + 1;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    logic [15:0] r_spacing;
    logic [15:0] r_surge_damp;
    logic [15:0] r_sway_damp;
    logic [15:0] r_yaw_damp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing    <= dtm_pkg::SPACING_RST;
            r_surge_damp <= '0;
            r_sway_damp  <= '0;
            r_yaw_damp   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dtm_pkg::REG_SPACING:    r_spacing    <= i_cfg_data;
                dtm_pkg::REG_SURGE_DAMP: r_surge_damp <= i_cfg_data;
                dtm_pkg::REG_SWAY_DAMP:  r_sway_damp  <= i_cfg_data;
                dtm_pkg::REG_YAW_DAMP:   r_yaw_damp   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pipeline control: a stage loads when empty or when the next one loads
    // ------------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NSTG-1];

    // ------------------------------------------------------------------------
    // stage A: mix and drag products
    // ------------------------------------------------------------------------
    dtm_pkg::t_stg_a r_a;
    dtm_pkg::t_stg_a n_a;

    always_comb begin
        n_a.l       = 17'(i_throttle) + 17'(i_steering);
        n_a.r       = 17'(i_throttle) - 17'(i_steering);
        n_a.p_surge = $signed({1'b0, r_surge_damp}) * i_surge_speed;
        n_a.p_sway  = $signed({1'b0, r_sway_damp}) * i_sway_speed;
        n_a.p_yaw   = $signed({1'b0, r_yaw_damp}) * i_yaw_speed;
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_A]) begin
            r_a <= n_a;
        end
    end

    // ------------------------------------------------------------------------
    // stage B: larger magnitude, divider set-up, drag rounding
    // ------------------------------------------------------------------------
    dtm_pkg::t_div r_div [0:dtm_pkg::DIV_STAGES];
    dtm_pkg::t_div n_div [0:dtm_pkg::DIV_STAGES];

    logic [16:0] b_la;
    logic [16:0] b_ra;
    logic [16:0] b_small;
    logic [30:0] b_num;

    always_comb begin
        b_la             = r_a.l[16] ? 17'(-r_a.l) : 17'(r_a.l);
        b_ra             = r_a.r[16] ? 17'(-r_a.r) : 17'(r_a.r);
        n_div[0].l       = r_a.l;
        n_div[0].r       = r_a.r;
        n_div[0].big_l   = b_la >= b_ra;
        n_div[0].mx      = n_div[0].big_l ? b_la : b_ra;
        b_small          = n_div[0].big_l ? b_ra : b_la;
        n_div[0].norm    = n_div[0].mx > 17'(dtm_pkg::ONE_Q14);
        b_num            = {b_small, 14'b0} + 31'(n_div[0].mx >> 1);
        n_div[0].rem     = 17'(b_num[30:dtm_pkg::DIV_BITS]);
        n_div[0].num     = b_num[dtm_pkg::DIV_BITS-1:0];
        n_div[0].q       = '0;
        n_div[0].drag.surge = dtm_pkg::rnd_sat(34'(r_a.p_surge), dtm_pkg::DRAG_SH, 1'b1);
        n_div[0].drag.sway  = dtm_pkg::rnd_sat(34'(r_a.p_sway), dtm_pkg::DRAG_SH, 1'b1);
        n_div[0].drag.yaw   = dtm_pkg::rnd_sat(34'(r_a.p_yaw), dtm_pkg::DRAG_SH, 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_B]) begin
            r_div[0] <= n_div[0];
        end
    end

    // ------------------------------------------------------------------------
    // divider stages: restoring, DIV_STEP quotient bits each
    // ------------------------------------------------------------------------
    for (genvar s = 0; s < dtm_pkg::DIV_STAGES; s++) begin : g_div
        logic [17:0] trial;
        logic [16:0] rem;

        always_comb begin
            n_div[s+1] = r_div[s];
            rem        = r_div[s].rem;
            trial      = '0;
            for (int j = 0; j < dtm_pkg::DIV_STEP; j++) begin
                trial = {rem, r_div[s].num[dtm_pkg::DIV_BITS-1-(s*dtm_pkg::DIV_STEP+j)]};
                if (trial >= {1'b0, r_div[s].mx}) begin
                    rem = 17'(trial - {1'b0, r_div[s].mx});
                    n_div[s+1].q[dtm_pkg::DIV_BITS-1-(s*dtm_pkg::DIV_STEP+j)] = 1'b1;
                end else begin
                    rem = trial[16:0];
                end
            end
            n_div[s+1].rem = rem;
        end

        always_ff @(posedge i_clk) begin
            if (en[STG_B+1+s]) begin
                r_div[s+1] <= n_div[s+1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage C: normalised mix -> current magnitude and sign
    // ------------------------------------------------------------------------
    dtm_pkg::t_cur r_c;
    dtm_pkg::t_cur n_c;

    logic [dtm_pkg::DIV_BITS-1:0] c_lm;
    logic [dtm_pkg::DIV_BITS-1:0] c_rm;
    logic signed [16:0]           c_lv;
    logic signed [16:0]           c_rv;

    always_comb begin
        c_lm = r_div[dtm_pkg::DIV_STAGES].big_l ? dtm_pkg::DIV_BITS'(dtm_pkg::ONE_Q14)
                                                 : r_div[dtm_pkg::DIV_STAGES].q;
        c_rm = r_div[dtm_pkg::DIV_STAGES].big_l ? r_div[dtm_pkg::DIV_STAGES].q
                                                 : dtm_pkg::DIV_BITS'(dtm_pkg::ONE_Q14);
        if (r_div[dtm_pkg::DIV_STAGES].norm) begin
            c_lv = r_div[dtm_pkg::DIV_STAGES].l[16] ? -$signed({2'b0, c_lm})
                                                     : $signed({2'b0, c_lm});
            c_rv = r_div[dtm_pkg::DIV_STAGES].r[16] ? -$signed({2'b0, c_rm})
                                                     : $signed({2'b0, c_rm});
        end else begin
            c_lv = r_div[dtm_pkg::DIV_STAGES].l;
            c_rv = r_div[dtm_pkg::DIV_STAGES].r;
        end
        n_c.ls   = dtm_pkg::cur_of(c_lv);
        n_c.rs   = dtm_pkg::cur_of(c_rv);
        n_c.drag = r_div[dtm_pkg::DIV_STAGES].drag;
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_C]) begin
            r_c <= n_c;
        end
    end

    // ------------------------------------------------------------------------
    // stage E: square and linear term
    // ------------------------------------------------------------------------
    dtm_pkg::t_sq r_e;
    dtm_pkg::t_sq n_e;

    always_comb begin
        n_e.lsq  = 37'(r_c.ls.a * r_c.ls.a);
        n_e.rsq  = 37'(r_c.rs.a * r_c.rs.a);
        n_e.llin = 34'((r_c.ls.neg ? dtm_pkg::REV_C1 : dtm_pkg::FWD_C1) * r_c.ls.a);
        n_e.rlin = 34'((r_c.rs.neg ? dtm_pkg::REV_C1 : dtm_pkg::FWD_C1) * r_c.rs.a);
        n_e.lneg = r_c.ls.neg;
        n_e.rneg = r_c.rs.neg;
        n_e.drag = r_c.drag;
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_E]) begin
            r_e <= n_e;
        end
    end

    // ------------------------------------------------------------------------
    // stage F: quadratic term
    // ------------------------------------------------------------------------
    dtm_pkg::t_prod r_f;
    dtm_pkg::t_prod n_f;

    always_comb begin
        n_f.lquad = 50'((r_e.lneg ? dtm_pkg::REV_C2 : dtm_pkg::FWD_C2) * r_e.lsq);
        n_f.rquad = 50'((r_e.rneg ? dtm_pkg::REV_C2 : dtm_pkg::FWD_C2) * r_e.rsq);
        n_f.llin  = r_e.llin;
        n_f.rlin  = r_e.rlin;
        n_f.lneg  = r_e.lneg;
        n_f.rneg  = r_e.rneg;
        n_f.drag  = r_e.drag;
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_F]) begin
            r_f <= n_f;
        end
    end

    // ------------------------------------------------------------------------
    // stage G: thrust per side, Q8.8
    // ------------------------------------------------------------------------
    dtm_pkg::t_thr r_g;
    dtm_pkg::t_thr n_g;

    logic [50:0] g_lsum;
    logic [50:0] g_rsum;

    always_comb begin
        g_lsum = 51'(r_f.lquad) + 51'({r_f.llin, 14'b0})
               + (51'd1 << (dtm_pkg::CURVE_SH - 1));
        g_rsum = 51'(r_f.rquad) + 51'({r_f.rlin, 14'b0})
               + (51'd1 << (dtm_pkg::CURVE_SH - 1));
        n_g.lt   = r_f.lneg ? -$signed({1'b0, g_lsum[50:dtm_pkg::CURVE_SH]})
                            : $signed({1'b0, g_lsum[50:dtm_pkg::CURVE_SH]});
        n_g.rt   = r_f.rneg ? -$signed({1'b0, g_rsum[50:dtm_pkg::CURVE_SH]})
                            : $signed({1'b0, g_rsum[50:dtm_pkg::CURVE_SH]});
        n_g.drag = r_f.drag;
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_G]) begin
            r_g <= n_g;
        end
    end

    // ------------------------------------------------------------------------
    // stage H: surge sum and torque product
    // ------------------------------------------------------------------------
    dtm_pkg::t_trq r_h;
    dtm_pkg::t_trq n_h;

    logic signed [16:0] h_sum;
    logic signed [16:0] h_diff;

    always_comb begin
        h_sum  = 17'(r_g.lt) + 17'(r_g.rt);
        h_diff = 17'(r_g.lt) - 17'(r_g.rt);
        if (h_sum > 17'(dtm_pkg::MAX16)) begin
            n_h.surge = dtm_pkg::MAX16;
        end else if (h_sum < 17'(dtm_pkg::MIN16)) begin
            n_h.surge = dtm_pkg::MIN16;
        end else begin
            n_h.surge = 16'(h_sum);
        end
        n_h.tp   = h_diff * $signed({1'b0, r_spacing});
        n_h.drag = r_g.drag;
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_H]) begin
            r_h <= n_h;
        end
    end

    // ------------------------------------------------------------------------
    // stage I: torque rounding, output register
    // ------------------------------------------------------------------------
    dtm_pkg::t_res r_res;
    dtm_pkg::t_res n_res;

    always_comb begin
        n_res.surge  = r_h.surge;
        n_res.torque = dtm_pkg::rnd_sat(r_h.tp, dtm_pkg::TORQUE_SH, 1'b0);
        n_res.drag   = r_h.drag;
    end

    always_ff @(posedge i_clk) begin
        if (en[STG_I]) begin
            r_res <= n_res;
        end
    end

    assign o_surge_force = r_res.surge;
    assign o_yaw_torque  = r_res.torque;
    assign o_surge_drag  = r_res.drag.surge;
    assign o_sway_drag   = r_res.drag.sway;
    assign o_yaw_drag    = r_res.drag.yaw;

endmodule

`default_nettype wire
